>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the core's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/core/tkh_pkg.sv
// ----------------------------------------------------------------------------
// tkh_pkg
// Types, constants and helper functions of the top-k heap selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tkh_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_EMIT,
        ST_DUMP_RD,
        ST_DUMP_OUT
    } state_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]     item_value;
        logic        [COUNT_OUT_W-1:0] held_count;
        logic                          accepted;
        logic                          is_dump;
        logic                          is_last;
    } res_t;

    // Address bits for a memory of the given depth (at least one).
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // True if a belongs nearer the root than b: min-heap when keeping the
    // largest values, max-heap when keeping the smallest.
    function automatic logic closer(input logic signed [VALUE_W-1:0] a,
                                    input logic signed [VALUE_W-1:0] b,
                                    input logic                      keep_largest);
        return keep_largest ? (a < b) : (a > b);
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tkh_ram.sv
// ----------------------------------------------------------------------------
// tkh_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tkh_ram #(
    parameter int WIDTH = tkh_pkg::VALUE_W,
    parameter int DEPTH = tkh_pkg::CAPACITY_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [tkh_pkg::addr_w(DEPTH)-1:0]     wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [tkh_pkg::addr_w(DEPTH)-1:0]     rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);
    import tkh_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tkh_seq.sv
// ----------------------------------------------------------------------------
// tkh_seq
// Heap sequencer: accepts requests, runs sift-up and sift-down through the
// heap memory one level at a time, and streams dump results.
// ----------------------------------------------------------------------------
`default_nettype none

module tkh_seq #(
    parameter int CAPACITY = tkh_pkg::CAPACITY_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic                                     kind,
    input  wire logic signed [tkh_pkg::VALUE_W-1:0]       value,
    input  wire logic                                     keep_largest,
    output logic                                          res_valid,
    output tkh_pkg::res_t                                 res,
    input  wire logic                                     res_free,
    output logic                                          mem_wr_en,
    output logic [tkh_pkg::addr_w(CAPACITY)-1:0]          mem_wr_addr,
    output logic [tkh_pkg::VALUE_W-1:0]                   mem_wr_data,
    output logic                                          mem_rd_en,
    output logic [tkh_pkg::addr_w(CAPACITY)-1:0]          mem_rd_addr,
    input  wire logic [tkh_pkg::VALUE_W-1:0]              mem_rd_data
);
    import tkh_pkg::*;

    localparam int AddrW = addr_w(CAPACITY);
    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int ChW   = CntW + 1;

    state_t state_reg, state_next;

    logic [CntW-1:0]           fill_reg, fill_next;
    logic [CntW-1:0]           pos_reg, pos_next;
    logic [CntW-1:0]           idx_reg, idx_next;
    logic                      acc_reg, acc_next;
    logic                      dump_reg, dump_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] best_val_reg, best_val_next;
    logic                      best_l_reg, best_l_next;
    logic                      r_ok_reg, r_ok_next;
    logic signed [VALUE_W-1:0] root_reg;

    logic signed [VALUE_W-1:0] rd_val;
    logic [ChW-1:0]            lchild, rchild, fill_ext;
    logic [CntW-1:0]           parent;
    logic                      heap_full;
    logic                      dump_last;

    assign rd_val    = mem_rd_data;
    assign lchild    = (ChW'(pos_reg) << 1) + ChW'(1);
    assign rchild    = lchild + ChW'(1);
    assign fill_ext  = ChW'(fill_reg);
    assign parent    = (pos_reg - CntW'(1)) >> 1;
    assign heap_full = (fill_reg == CntW'(CAPACITY));
    assign dump_last = ((ChW'(idx_reg) + ChW'(1)) == fill_ext);
    assign in_stall  = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    // Datapath registers; the root copy mirrors every write to entry zero.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        acc_reg      <= acc_next;
        dump_reg     <= dump_next;
        val_reg      <= val_next;
        best_val_reg <= best_val_next;
        best_l_reg   <= best_l_next;
        r_ok_reg     <= r_ok_next;
        if (mem_wr_en && (mem_wr_addr == AddrW'(0)))
        begin
            root_reg <= mem_wr_data;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        dump_next     = dump_reg;
        val_next      = val_reg;
        best_val_next = best_val_reg;
        best_l_next   = best_l_reg;
        r_ok_next     = r_ok_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = pos_reg[AddrW-1:0];
        mem_wr_data = val_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = lchild[AddrW-1:0];

        res_valid      = 1'b0;
        res.item_value = dump_reg ? '0 : root_reg;
        res.held_count = COUNT_OUT_W'(fill_reg);
        res.accepted   = acc_reg & ~dump_reg;
        res.is_dump    = dump_reg;
        res.is_last    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    val_next = value;
                    idx_next = '0;
                    if (kind == KIND_DUMP)
                    begin
                        dump_next  = 1'b1;
                        acc_next   = 1'b0;
                        state_next = (fill_reg == '0) ? ST_EMIT : ST_DUMP_RD;
                    end
                    else
                    begin
                        dump_next = 1'b0;
                        if (!heap_full)
                        begin
                            acc_next   = 1'b1;
                            pos_next   = fill_reg;
                            fill_next  = fill_reg + CntW'(1);
                            state_next = ST_UP_RD;
                        end
                        else if (closer(root_reg, value, keep_largest))
                        begin
                            acc_next   = 1'b1;
                            pos_next   = '0;
                            state_next = ST_DN_RDL;
                        end
                        else
                        begin
                            acc_next   = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            // The new value rides in val_reg; parents move down until it settles.
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_wr_en  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = parent[AddrW-1:0];
                    state_next  = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                mem_wr_en = 1'b1;
                if (closer(val_reg, rd_val, keep_largest))
                begin
                    mem_wr_data = rd_val;
                    pos_next    = parent;
                    state_next  = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_DN_RDL:
            begin
                if (lchild >= fill_ext)
                begin
                    mem_wr_en  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_DN_RDR;
                end
            end

            // Left child data is here; pick the better of it and the sifted value.
            ST_DN_RDR:
            begin
                best_l_next   = closer(rd_val, val_reg, keep_largest);
                best_val_next = best_l_next ? rd_val : val_reg;
                r_ok_next     = (rchild < fill_ext);
                mem_rd_en     = r_ok_next;
                mem_rd_addr   = rchild[AddrW-1:0];
                state_next    = ST_DN_CMP;
            end

            ST_DN_CMP:
            begin
                mem_wr_en = 1'b1;
                if (r_ok_reg && closer(rd_val, best_val_reg, keep_largest))
                begin
                    mem_wr_data = rd_val;
                    pos_next    = CntW'(rchild);
                    state_next  = ST_DN_RDL;
                end
                else if (best_l_reg)
                begin
                    mem_wr_data = best_val_reg;
                    pos_next    = CntW'(lchild);
                    state_next  = ST_DN_RDL;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                res_valid = 1'b1;
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DUMP_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg[AddrW-1:0];
                state_next  = ST_DUMP_OUT;
            end

            ST_DUMP_OUT:
            begin
                res_valid      = 1'b1;
                res.item_value = rd_val;
                res.is_last    = dump_last;
                if (res_free)
                begin
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CntW'(1);
                        state_next = ST_DUMP_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/top_k_heap_selector_core.sv
// ----------------------------------------------------------------------------
// top_k_heap_selector_core
// Keeps the CAPACITY largest or smallest signed values in a memory heap.
// ----------------------------------------------------------------------------
// The block takes one request at a time and holds in_stall high until that
// request's results have been handed to the output register. A push that is
// dropped goes straight to the output; a push into a heap that is not yet
// full climbs from the new leaf toward the root, and a push that replaces
// the root descends toward the leaves. Each level needs one or two reads of
// the single heap memory port plus a write. A dump gives one result per
// memory read, and each read waits until the previous result has been taken.
// keep_largest resets to 1 (keep the largest values) and must only be
// written while no request is in flight.
`default_nettype none

`include "assert_macros.svh"

module top_k_heap_selector_core #(
    parameter int CAPACITY = tkh_pkg::CAPACITY_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 kind,
    input  wire logic signed [tkh_pkg::VALUE_W-1:0]   value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [tkh_pkg::VALUE_W-1:0]        item_value,
    output logic [tkh_pkg::COUNT_OUT_W-1:0]           held_count,
    output logic                                      accepted,
    output logic                                      is_dump,
    output logic                                      is_last,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic                                 keep_largest
);
    import tkh_pkg::*;

    localparam int AddrW = addr_w(CAPACITY);

    logic                keep_largest_reg;
    logic                res_valid;
    res_t                res;
    logic                res_free;
    res_t                out_reg;
    logic                out_valid_reg;

    logic                mem_wr_en;
    logic [AddrW-1:0]    mem_wr_addr;
    logic [VALUE_W-1:0]  mem_wr_data;
    logic                mem_rd_en;
    logic [AddrW-1:0]    mem_rd_addr;
    logic [VALUE_W-1:0]  mem_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_largest_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            keep_largest_reg <= keep_largest;
        end
    end

    tkh_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .value        (value),
        .keep_largest (keep_largest_reg),
        .res_valid    (res_valid),
        .res          (res),
        .res_free     (res_free),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    tkh_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: a new result loads whenever the slot is empty or
    // being drained in the same cycle.
    assign res_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_free)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign item_value = out_reg.item_value;
    assign held_count = out_reg.held_count;
    assign accepted   = out_reg.accepted;
    assign is_dump    = out_reg.is_dump;
    assign is_last    = out_reg.is_last;

    `ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_SAME(a_push_single_result, clk, rst_n, out_valid && !is_dump, is_last)
    `ASSERT_SAME(a_dump_not_accepted, clk, rst_n, out_valid && is_dump, !accepted)

endmodule

`default_nettype wire
